### design/rss_pkg.sv
`default_nettype none
package rss_pkg;

   // Field widths of the request and response words.
   localparam int unsigned ValueW  = 32;
   localparam int unsigned RandW   = 31;
   localparam int unsigned CountW  = 11;
   localparam int unsigned ReqTdW  = 64;
   localparam int unsigned RspTdW  = 48;

   // The remainder unit retires one dividend bit per cycle.
   localparam int unsigned StepW   = 5;
   localparam logic [StepW-1:0] StepLast = 5'd30;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_SAMPLE = 2'd2,
      REQ_UNUSED = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NOCHANGE = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_SCAN    = 7'b0000010,
      S_RDLAST  = 7'b0000100,
      S_WRLAST  = 7'b0001000,
      S_MOD     = 7'b0010000,
      S_SMPDATA = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

endpackage
`default_nettype wire

### design/rss_mem.sv
`default_nettype none
module rss_mem
   import rss_pkg::*;
#(
   parameter int unsigned Depth = 1024,
   parameter int unsigned AddrW = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AddrW-1:0]  wr_addr,
   input  wire logic [ValueW-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AddrW-1:0]  rd_addr,
   output logic      [ValueW-1:0] rd_data
);

   logic [ValueW-1:0] mem [Depth];

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

### design/rss_mod.sv
`default_nettype none
module rss_mod
   import rss_pkg::*;
#(
   parameter int unsigned CntW = 11
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [RandW-1:0] dividend,
   input  wire logic [CntW-1:0]  divisor,
   output logic                  done,
   output logic      [CntW-1:0]  remainder
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [RandW-1:0] dvd_ff, dvd_in;
   logic [CntW-1:0]  rem_ff, rem_in;
   logic [CntW:0]    rem_shift;

   // Restoring remainder: shift in one dividend bit, subtract when it fits.
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      rem_shift = {rem_ff, dvd_ff[RandW-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, divisor}) begin
            rem_in = CntW'(rem_shift - {1'b0, divisor});
         end else begin
            rem_in = rem_shift[CntW-1:0];
         end
         dvd_in  = {dvd_ff[RandW-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == StepLast) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

### design/random_sample_set.sv
// Insert and remove scan the occupied entries at one per cycle; a remove that hits
// moves the last entry into the hole. A sample of a non-empty set waits on the
// bit-serial remainder unit. Throughput: one request at a time; the next is taken
// once the response word is in the output register. Reset clears count and control.
`default_nettype none
module random_sample_set
   import rss_pkg::*;
#(
   parameter int unsigned CAPACITY = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // req_tdata: item_value [31:0], random_word [62:32], zero [63]
   input  wire logic [ReqTdW-1:0] req_tdata,
   // req_tuser: req_type [1:0]
   input  wire logic [1:0]        req_tuser,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // rsp_tdata: sample_value [31:0], member_count [42:32], zero [47:43]
   output logic      [RspTdW-1:0] rsp_tdata,
   // rsp_tuser: success [0], status [2:1]
   output logic      [2:0]        rsp_tuser,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready
);

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

   state_type         state_ff, state_in;
   req_kind_type      op_ff, op_in;
   logic [ValueW-1:0] value_ff, value_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pend_idx_ff, pend_idx_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic              res_ok_ff, res_ok_in;
   logic [ValueW-1:0] res_smp_ff, res_smp_in;
   status_type        res_st_ff, res_st_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RspTdW-1:0] rsp_data_ff, rsp_data_in;
   logic [2:0]        rsp_user_ff, rsp_user_in;

   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [ValueW-1:0] mem_wdata, mem_rdata;
   logic              mod_start, mod_done;
   logic [CW-1:0]     mod_rem;
   logic              hit;
   logic              req_fire;
   logic [CW+CountW-1:0] count_ext;

   rss_mem #(.Depth(CAPACITY), .AddrW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   rss_mod #(.CntW(CW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_tdata[ValueW +: RandW]),
      .divisor   (count_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign hit        = pend_ff && (mem_rdata == value_ff);
   assign count_ext  = {{CountW{1'b0}}, count_ff};

   // Request sequencer: scan, swap, sample and response hand-off.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      pos_in       = pos_ff;
      res_ok_in    = res_ok_ff;
      res_smp_in   = res_smp_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[AW-1:0];
      mem_wdata    = value_ff;
      mem_re       = 1'b0;
      mem_raddr    = idx_ff[AW-1:0];
      mod_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in      = req_kind_type'(req_tuser);
               value_in   = req_tdata[ValueW-1:0];
               idx_in     = '0;
               res_ok_in  = 1'b0;
               res_smp_in = '0;
               res_st_in  = ST_DONE;
               case (req_kind_type'(req_tuser))
                  REQ_INSERT, REQ_REMOVE: begin
                     state_in = S_SCAN;
                  end
                  REQ_SAMPLE: begin
                     res_ok_in = 1'b1;
                     if (count_ff == '0) begin
                        res_st_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        mod_start = 1'b1;
                        state_in  = S_MOD;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               pos_in = pend_idx_ff;
               if (op_ff == REQ_REMOVE) begin
                  state_in = S_RDLAST;
               end else begin
                  res_st_in = ST_NOCHANGE;
                  state_in  = S_DONE;
               end
            end else if (!pend_ff && idx_ff == count_ff) begin
               // Whole occupied range compared without a match.
               if (op_ff == REQ_REMOVE) begin
                  res_st_in = ST_NOCHANGE;
               end else if (count_ff == CapCount) begin
                  res_st_in = ST_FULL;
               end else begin
                  mem_we    = 1'b1;
                  count_in  = count_ff + 1'b1;
                  res_ok_in = 1'b1;
               end
               state_in = S_DONE;
            end else if (idx_ff != count_ff) begin
               mem_re      = 1'b1;
               idx_in      = idx_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff[AW-1:0];
            end
         end
         S_RDLAST: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(count_ff - 1'b1);
            state_in  = S_WRLAST;
         end
         S_WRLAST: begin
            // Move the last entry into the freed slot.
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = mem_rdata;
            count_in  = count_ff - 1'b1;
            res_ok_in = 1'b1;
            state_in  = S_DONE;
         end
         S_MOD: begin
            if (mod_done) begin
               mem_re    = 1'b1;
               mem_raddr = mod_rem[AW-1:0];
               state_in  = S_SMPDATA;
            end
         end
         S_SMPDATA: begin
            res_smp_in = mem_rdata;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RspTdW - ValueW - CountW){1'b0}},
                               count_ext[CountW-1:0], res_smp_ff};
               rsp_user_in  = {res_st_ff, res_ok_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      value_ff    <= value_in;
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      pos_ff      <= pos_in;
      res_ok_ff   <= res_ok_in;
      res_smp_ff  <= res_smp_in;
      res_st_ff   <= res_st_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire
